@@ rtl/core/obrt_pkg.sv @@
// Package for the object block reassembly tracker: constants, codes and the command type.
`timescale 1ns / 1ps
package obrt_pkg;

  localparam int SLOTS_DEF      = 256;
  localparam int MAX_BLOCKS_DEF = 64;
  localparam int CNT_W          = 13;  // holds a block count up to the largest MAX_BLOCKS
  localparam int DIV_STEPS      = 24;  // one quotient bit per cycle over the object size

  typedef enum logic [3:0] {
    EV_INFO_OK    = 4'd0,
    EV_INFO_REJ   = 4'd1,
    EV_ABORTED    = 4'd2,
    EV_STORED     = 4'd3,
    EV_DUPLICATE  = 4'd4,
    EV_COMPLETE   = 4'd5,
    EV_DROP_INACT = 4'd6,
    EV_DROP_GEN   = 4'd7,
    EV_DROP_RANGE = 4'd8,
    EV_DROP_HASH  = 4'd9
  } event_t;

  localparam logic FUNC_INFO = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  typedef struct packed {
    logic             func;
    logic             reject;
    logic             hash_ok;
    logic [7:0]       obj;
    logic [7:0]       slot;
    logic [15:0]      gen;
    logic [23:0]      size;
    logic [15:0]      bs;
    logic [CNT_W-1:0] count;
    logic [15:0]      bidx;
    logic [15:0]      blen;
  } cmd_t;

endpackage

@@ rtl/core/obrt_front.sv @@
// Front end: takes transactions, computes the block count and classifies them.
`timescale 1ns / 1ps
module obrt_front
  import obrt_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [7:0]  obj_index,
  input  logic [15:0] object_gen,
  input  logic [23:0] object_size,
  input  logic [15:0] block_size,
  input  logic [15:0] block_index,
  input  logic [15:0] block_length,
  input  logic [31:0] payload_hash,
  input  logic [31:0] expected_hash,
  output logic        push,
  output cmd_t        push_cmd,
  input  logic        full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t     state;
  cmd_t        cmd;
  logic [15:0] rem;
  logic [23:0] quo;
  logic [4:0]  step;

  logic [16:0] trial;
  logic [24:0] count_full;

  // slot = index mod SLOTS, one conditional subtract per index bit
  function automatic logic [7:0] slot_of(logic [7:0] obj);
    logic [8:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[7:0], obj[i]};
      if (r >= 9'(SLOTS)) r = r - 9'(SLOTS);
    end
    return r[7:0];
  endfunction

  assign trial      = {rem, quo[23]};
  assign count_full = {1'b0, quo} + {24'd0, (rem != 16'd0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            if (func == FUNC_INFO && block_size != 16'd0) state <= F_DIV;
            else state <= F_PUSH;
          end
        end
        F_DIV: begin
          if (step == 5'(DIV_STEPS - 1)) state <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && start) begin
      cmd.func    <= func;
      cmd.reject  <= (block_size == 16'd0);
      cmd.hash_ok <= (payload_hash == expected_hash);
      cmd.obj     <= obj_index;
      cmd.slot    <= slot_of(obj_index);
      cmd.gen     <= object_gen;
      cmd.size    <= object_size;
      cmd.bs      <= block_size;
      cmd.count   <= '0;
      cmd.bidx    <= block_index;
      cmd.blen    <= block_length;
      rem         <= '0;
      quo         <= object_size;
      step        <= '0;
    end else if (state == F_DIV) begin
      step <= step + 5'd1;
      if (trial >= {1'b0, cmd.bs}) begin
        rem <= 16'(trial - {1'b0, cmd.bs});
        quo <= {quo[22:0], 1'b1};
      end else begin
        rem <= trial[15:0];
        quo <= {quo[22:0], 1'b0};
      end
      if (step == 5'(DIV_STEPS - 1)) begin
        // last quotient bit lands next cycle; count is taken in F_PUSH
      end
    end
  end

  always_comb begin
    push_cmd = cmd;
    if (cmd.func == FUNC_INFO && !cmd.reject) begin
      push_cmd.count  = count_full[CNT_W-1:0];
      push_cmd.reject = (count_full > 25'(MAX_BLOCKS));
    end
  end

  assign push = (state == F_PUSH) && !full;
  assign busy = (state != F_IDLE);

endmodule

@@ rtl/core/obrt_queue.sv @@
// Two-entry command queue between front end and back end.
`timescale 1ns / 1ps
module obrt_queue
  import obrt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  assign dout  = mem[rp];
  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);

endmodule

@@ rtl/core/obrt_back.sv @@
// Back end: slot table read-modify-write and result sequencing.
`timescale 1ns / 1ps
module obrt_back
  import obrt_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  cmd_t        head,
  output logic        pop,
  output logic        valid,
  output logic [3:0]  event_res,
  output logic [7:0]  slot_object,
  output logic [15:0] event_gen,
  output logic [23:0] write_offset,
  output logic [23:0] length,
  output logic        last
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  typedef struct packed {
    logic [15:0]   gen;
    logic [23:0]   size;
    logic [15:0]   bs;
    logic [CW-1:0] count;
    logic [CW-1:0] recv;
  } entry_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_EXEC = 3'b010,
    B_EMIT = 3'b100
  } bstate_t;

  bstate_t               state;
  logic [SLOTS-1:0]      act;
  entry_t                ent_mem [SLOTS];
  logic [MAX_BLOCKS-1:0] map_mem [SLOTS];
  entry_t                ent_q;
  logic [MAX_BLOCKS-1:0] map_q;
  logic                  act_q;
  cmd_t                  cur;

  logic [3:0]  pend_ev;
  logic [15:0] pend_gen;
  logic [23:0] pend_len;

  logic [SW-1:0]         slot;
  logic [BW-1:0]         bit_sel;
  logic                  is_new;
  logic [CW-1:0]         new_recv;
  logic                  fin;
  logic                  in_range;
  logic [31:0]           offset;
  logic [MAX_BLOCKS-1:0] map_set;

  assign slot     = cur.slot[SW-1:0];
  assign bit_sel  = cur.bidx[BW-1:0];
  assign is_new   = !map_q[bit_sel];
  assign new_recv = ent_q.recv + CW'(is_new);
  assign fin      = (new_recv == ent_q.count);
  assign in_range = (cur.bidx < 16'(ent_q.count));
  assign offset   = cur.bidx * ent_q.bs;
  assign map_set  = map_q | (MAX_BLOCKS'(1) << bit_sel);
  assign pop      = (state == B_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      act   <= '0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!empty) state <= B_EXEC;
        end
        B_EXEC: begin
          valid <= 1'b1;
          state <= B_IDLE;
          if (cur.func == FUNC_INFO) begin
            act[slot] <= !cur.reject;
            if (act_q) state <= B_EMIT;
          end else if (act_q && ent_q.gen == cur.gen && in_range && cur.hash_ok && fin) begin
            act[slot] <= 1'b0;
            state     <= B_EMIT;
          end
        end
        B_EMIT: begin
          valid <= 1'b1;
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // table read for the next command
  always_ff @(posedge clk) begin
    if (pop) begin
      cur   <= head;
      ent_q <= ent_mem[head.slot[SW-1:0]];
      map_q <= map_mem[head.slot[SW-1:0]];
      act_q <= act[head.slot[SW-1:0]];
    end
  end

  // table write-back
  always_ff @(posedge clk) begin
    if (state == B_EXEC) begin
      if (cur.func == FUNC_INFO) begin
        if (!cur.reject) begin
          ent_mem[slot] <= '{gen: cur.gen, size: cur.size, bs: cur.bs,
                             count: cur.count[CW-1:0], recv: '0};
          map_mem[slot] <= '0;
        end
      end else if (act_q && ent_q.gen == cur.gen && in_range && cur.hash_ok && is_new) begin
        ent_mem[slot] <= '{gen: ent_q.gen, size: ent_q.size, bs: ent_q.bs,
                           count: ent_q.count, recv: new_recv};
        map_mem[slot] <= map_set;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_EXEC) begin
      slot_object  <= cur.obj;
      event_gen    <= cur.gen;
      write_offset <= '0;
      length       <= '0;
      last         <= 1'b1;
      pend_ev      <= cur.reject ? EV_INFO_REJ : EV_INFO_OK;
      pend_gen     <= cur.gen;
      pend_len     <= '0;
      if (cur.func == FUNC_INFO) begin
        if (act_q) begin
          event_res <= EV_ABORTED;
          event_gen <= ent_q.gen;
          last      <= 1'b0;
        end else begin
          event_res <= cur.reject ? EV_INFO_REJ : EV_INFO_OK;
        end
      end else if (!act_q) begin
        event_res <= EV_DROP_INACT;
      end else if (ent_q.gen != cur.gen) begin
        event_res <= EV_DROP_GEN;
      end else if (!in_range) begin
        event_res <= EV_DROP_RANGE;
      end else if (!cur.hash_ok) begin
        event_res <= EV_DROP_HASH;
      end else begin
        last     <= !fin;
        pend_ev  <= EV_COMPLETE;
        pend_gen <= ent_q.gen;
        pend_len <= ent_q.size;
        if (is_new) begin
          event_res    <= EV_STORED;
          write_offset <= offset[23:0];
          length       <= {8'd0, cur.blen};
        end else begin
          event_res <= EV_DUPLICATE;
        end
      end
    end else if (state == B_EMIT) begin
      event_res    <= pend_ev;
      event_gen    <= pend_gen;
      write_offset <= '0;
      length       <= pend_len;
      last         <= 1'b1;
    end
  end

endmodule

@@ rtl/core/object_block_reassembly_tracker_unit.sv @@
// Top level of the object block reassembly tracker.
// Usage:
//   A transaction is taken at a rising edge where start is high and busy is low.
//   func selects an info announcement (0) or a data block (1); all other input
//   ports carry that transaction's fields.
//   Results appear for exactly one cycle with valid high; one transaction gives
//   one or two results, and last marks the final one. The receiver cannot stall.
// Flow:
//   A data transaction holds busy until the front end pushes it to the queue.
//   An info transaction with a nonzero block_size first runs a bit-serial
//   divider for the block count and holds busy until its command is pushed.
//   The back end pops each command, reads the slot table and then registers
//   its results. Rate is set by the front-end divider for info and by the
//   slot table read-modify-write for data; a two-entry queue lets the front
//   end take the next transaction while the back end works.
// Reset:
//   rst (synchronous) marks every slot inactive and empties the queue; no
//   clearing pass is needed, so the block is ready in the cycle after reset.
`timescale 1ns / 1ps
module object_block_reassembly_tracker_unit
  import obrt_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [7:0]  obj_index,
  input  logic [15:0] object_gen,
  input  logic [23:0] object_size,
  input  logic [15:0] block_size,
  input  logic [15:0] block_index,
  input  logic [15:0] block_length,
  input  logic [31:0] payload_hash,
  input  logic [31:0] expected_hash,
  output logic        valid,
  output logic [3:0]  event_res,
  output logic [7:0]  slot_object,
  output logic [15:0] event_gen,
  output logic [23:0] write_offset,
  output logic [23:0] length,
  output logic        last
);

  logic push;
  logic full;
  logic pop;
  logic empty;
  cmd_t push_cmd;
  cmd_t head;

  obrt_front #(.SLOTS(SLOTS), .MAX_BLOCKS(MAX_BLOCKS)) u_front (
    .clk, .rst, .start, .busy, .func, .obj_index, .object_gen, .object_size,
    .block_size, .block_index, .block_length, .payload_hash, .expected_hash,
    .push, .push_cmd, .full
  );

  obrt_queue u_queue (
    .clk, .rst, .push, .din(push_cmd), .full, .pop, .dout(head), .empty
  );

  obrt_back #(.SLOTS(SLOTS), .MAX_BLOCKS(MAX_BLOCKS)) u_back (
    .clk, .rst, .empty, .head, .pop, .valid, .event_res, .slot_object,
    .event_gen, .write_offset, .length, .last
  );

endmodule
